FILE: src/mmp_pkg.sv
// Shared constants for the Michaelis-Menten propensity pipeline.
package mmp_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int KM_W    = 32;
    localparam int KCAT_W  = 32;
    localparam int PROP_W  = 52;
    localparam int FREE_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KCAT = 2'd1;

endpackage

FILE: src/mmp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module mmp_sqrt import mmp_pkg::*; #(
    parameter int RADW = 68,
    parameter int SBW  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [RADW-1:0]     i_rad,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_vld,
    output logic [RADW/2-1:0]   o_root,
    output logic [SBW-1:0]      o_sb
);
    localparam int N   = RADW / 2;
    localparam int RMW = N + 3;

    logic [RADW-1:0] r_x   [0:N-1];
    logic [RMW-1:0]  r_rem [0:N];
    logic [N-1:0]    r_rt  [0:N];
    logic            r_v   [0:N];
    logic [SBW-1:0]  r_sb  [0:N];

    assign r_x[0]   = i_rad;
    assign r_rem[0] = '0;
    assign r_rt[0]  = '0;
    assign r_v[0]   = i_vld;
    assign r_sb[0]  = i_sb;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RMW-1:0] n_rem;
        logic [RMW-1:0] trial;
        always_comb begin
            n_rem = {r_rem[k][RMW-3:0], r_x[k][RADW-1:RADW-2]};
            trial = {1'b0, r_rt[k], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k+1] <= r_sb[k];
                if (n_rem >= trial) begin
                    r_rem[k+1] <= n_rem - trial;
                    r_rt[k+1]  <= {r_rt[k][N-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_rem;
                    r_rt[k+1]  <= {r_rt[k][N-2:0], 1'b0};
                end
            end
        end

        if (k < N - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k+1] <= r_x[k] << 2;
                end
            end
        end
    end

    assign o_vld  = r_v[N];
    assign o_root = r_rt[N];
    assign o_sb   = r_sb[N];

endmodule

FILE: src/mmp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module mmp_div import mmp_pkg::*; #(
    parameter int QW  = 52,
    parameter int DW  = 35,
    parameter int SBW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [QW-1:0]   i_num,
    input  logic [DW-1:0]   i_rem,
    input  logic [DW-1:0]   i_den,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_vld,
    output logic [QW-1:0]   o_quo,
    output logic [SBW-1:0]  o_sb
);
    logic [QW-1:0]  r_n   [0:QW-1];
    logic [DW-1:0]  r_rem [0:QW-1];
    logic [DW-1:0]  r_den [0:QW-1];
    logic [QW-1:0]  r_q   [0:QW];
    logic           r_v   [0:QW];
    logic [SBW-1:0] r_sb  [0:QW];

    assign r_n[0]   = i_num;
    assign r_rem[0] = i_rem;
    assign r_den[0] = i_den;
    assign r_q[0]   = '0;
    assign r_v[0]   = i_vld;
    assign r_sb[0]  = i_sb;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] n_rem;
        logic [DW:0] n_sub;
        logic        take;
        always_comb begin
            n_rem = {r_rem[k], r_n[k][QW-1]};
            n_sub = n_rem - {1'b0, r_den[k]};
            take  = n_rem >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb[k+1] <= r_sb[k];
                r_q[k+1]  <= {r_q[k][QW-2:0], take};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k+1]   <= r_n[k] << 1;
                    r_den[k+1] <= r_den[k];
                    r_rem[k+1] <= take ? n_sub[DW-1:0] : n_rem[DW-1:0];
                end
            end
        end
    end

    assign o_vld = r_v[QW];
    assign o_quo = r_q[QW];
    assign o_sb  = r_sb[QW];

endmodule

FILE: src/michaelis_menten_propensity_top.sv
// Throughput one request per cycle while the result side does not stall.
// The sqrt (one bit per stage) and the divider (one quotient bit per stage) set the depth.
// The whole pipeline advances together; a stall on the result side while a result is held holds every stage.
// Synchronous active-low reset clears valid bits and sets Km and kcat to 0.
// Top level: total-QSSA Michaelis-Menten free substrate and propensity.
module michaelis_menten_propensity_top import mmp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COUNT_BITS-1:0] i_substrate_count,
    input  logic [COUNT_BITS-1:0] i_enzyme_count,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PROP_W-1:0]     o_propensity,
    output logic [FREE_W-1:0]     o_free_substrate,
    output logic                  o_undefined_rate
);
    localparam int SW    = COUNT_BITS + FRAC_BITS;
    localparam int MW    = ((KM_W > SW) ? KM_W : SW) + 1;
    localparam int RADW  = 2 * MW + 2;
    localparam int ROOTW = RADW / 2;
    localparam int DENW  = ROOTW + 1;
    localparam int AW    = KCAT_W + ROOTW;
    localparam int NUMW  = AW + COUNT_BITS;
    localparam int HIW   = NUMW - PROP_W;
    localparam int CW    = (HIW > DENW) ? HIW : DENW;
    localparam int SQ_SB = 1 + MW + COUNT_BITS;
    localparam int DV_SB = 2 + FREE_W;

    logic [KM_W-1:0]   r_km;
    logic [KCAT_W-1:0] r_kcat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_km   <= '0;
            r_kcat <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KM:   r_km   <= i_cfg_data[KM_W-1:0];
                CFG_KCAT: r_kcat <= i_cfg_data[KCAT_W-1:0];
                default:  ;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en         = !r_ov || !i_out_stall;
    assign o_in_stall = !en;

    // stage 1: scale counts
    logic            r1_v;
    logic [SW-1:0]   r1_sf;
    logic [MW-1:0]   r1_neg;
    logic [COUNT_BITS-1:0] r1_e;
    // stage 2: |S - Km - E|
    logic            r2_v, r2_ge;
    logic [MW-1:0]   r2_mag;
    logic [SW-1:0]   r2_sf;
    logic [COUNT_BITS-1:0] r2_e;
    // stage 3: products
    logic            r3_v, r3_ge;
    logic [2*MW-1:0] r3_sq;
    logic [KM_W+SW-1:0] r3_t;
    logic [MW-1:0]   r3_mag;
    logic [COUNT_BITS-1:0] r3_e;
    // stage 4: radicand
    logic            r4_v, r4_ge;
    logic [RADW-1:0] r4_rad;
    logic [MW-1:0]   r4_mag;
    logic [COUNT_BITS-1:0] r4_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sf  <= SW'(i_substrate_count) << FRAC_BITS;
            r1_neg <= MW'(r_km) + (MW'(i_enzyme_count) << FRAC_BITS);
            r1_e   <= i_enzyme_count;

            r2_ge  <= MW'(r1_sf) >= r1_neg;
            r2_mag <= (MW'(r1_sf) >= r1_neg) ? (MW'(r1_sf) - r1_neg)
                                             : (r1_neg - MW'(r1_sf));
            r2_sf  <= r1_sf;
            r2_e   <= r1_e;

            r3_sq  <= (2*MW)'(r2_mag) * (2*MW)'(r2_mag);
            r3_t   <= (KM_W+SW)'(r_km) * (KM_W+SW)'(r2_sf);
            r3_mag <= r2_mag;
            r3_ge  <= r2_ge;
            r3_e   <= r2_e;

            r4_rad <= RADW'(r3_sq) + (RADW'(r3_t) << 2);
            r4_mag <= r3_mag;
            r4_ge  <= r3_ge;
            r4_e   <= r3_e;
        end
    end

    logic             sq_v;
    logic [ROOTW-1:0] sq_root;
    logic [SQ_SB-1:0] sq_sb;

    mmp_sqrt #(.RADW(RADW), .SBW(SQ_SB)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r4_v),
        .i_rad  (r4_rad),
        .i_sb   ({r4_ge, r4_mag, r4_e}),
        .o_vld  (sq_v),
        .o_root (sq_root),
        .o_sb   (sq_sb)
    );

    logic                  sq_ge;
    logic [MW-1:0]         sq_mag;
    logic [COUNT_BITS-1:0] sq_e;
    logic [ROOTW:0]        sum_rm;
    logic [ROOTW-1:0]      n_sfree;

    always_comb begin
        {sq_ge, sq_mag, sq_e} = sq_sb;
        sum_rm = (ROOTW+1)'(sq_root) + (ROOTW+1)'(sq_mag);
        if (sq_ge) begin
            n_sfree = sum_rm[ROOTW:1];
        end else if (sq_root >= ROOTW'(sq_mag)) begin
            n_sfree = (sq_root - ROOTW'(sq_mag)) >> 1;
        end else begin
            n_sfree = '0;
        end
    end

    // stage 5..8: free substrate, numerator, denominator, overflow check
    logic             r5_v, r6_v, r7_v, r8_v;
    logic [ROOTW-1:0] r5_sfree, r6_sfree, r7_sfree;
    logic [COUNT_BITS-1:0] r5_e, r6_e;
    logic [AW-1:0]    r6_a;
    logic [DENW-1:0]  r6_den, r7_den, r8_den;
    logic [NUMW-1:0]  r7_num;
    logic [PROP_W-1:0] r8_lo;
    logic [DENW-1:0]  r8_rem;
    logic             r8_ovf, r8_zero;
    logic [FREE_W-1:0] r8_free;

    logic [CW-1:0] hi_x, den_x;
    always_comb begin
        hi_x  = CW'(r7_num[NUMW-1:PROP_W]);
        den_x = CW'(r7_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r5_v <= sq_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sfree <= n_sfree;
            r5_e     <= sq_e;

            r6_a     <= AW'(r_kcat) * AW'(r5_sfree);
            r6_den   <= DENW'(r_km) + DENW'(r5_sfree);
            r6_sfree <= r5_sfree;
            r6_e     <= r5_e;

            r7_num   <= NUMW'(r6_a) * NUMW'(r6_e);
            r7_den   <= r6_den;
            r7_sfree <= r6_sfree;

            // quotient above 52 bits iff the high part already reaches den
            r8_ovf   <= hi_x >= den_x;
            r8_zero  <= r7_den == '0;
            r8_rem   <= (hi_x >= den_x) ? '0 : DENW'(hi_x);
            r8_lo    <= r7_num[PROP_W-1:0];
            r8_den   <= r7_den;
            r8_free  <= (|r7_sfree[ROOTW-1:FREE_W]) ? '1 : r7_sfree[FREE_W-1:0];
        end
    end

    logic              dv_v;
    logic [PROP_W-1:0] dv_q;
    logic [DV_SB-1:0]  dv_sb;

    mmp_div #(.QW(PROP_W), .DW(DENW), .SBW(DV_SB)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r8_v),
        .i_num  (r8_lo),
        .i_rem  (r8_rem),
        .i_den  (r8_den),
        .i_sb   ({r8_zero, r8_ovf, r8_free}),
        .o_vld  (dv_v),
        .o_quo  (dv_q),
        .o_sb   (dv_sb)
    );

    logic              dv_zero, dv_ovf;
    logic [FREE_W-1:0] dv_free;
    logic [PROP_W-1:0] n_prop;
    always_comb begin
        {dv_zero, dv_ovf, dv_free} = dv_sb;
        if (dv_zero) begin
            n_prop = '0;
        end else if (dv_ovf) begin
            n_prop = '1;
        end else begin
            n_prop = dv_q;
        end
    end

    logic [PROP_W-1:0] r_prop;
    logic [FREE_W-1:0] r_free;
    logic              r_undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prop  <= n_prop;
            r_free  <= dv_free;
            r_undef <= dv_zero;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_propensity     = r_prop;
    assign o_free_substrate = r_free;
    assign o_undefined_rate = r_undef;

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_undefined_rate |-> o_propensity == '0 && o_free_substrate == '0)
        else $error("undefined rate with nonzero result");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output empty");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r4_v) && $stable(r8_v) && $stable(o_propensity))
        else $error("pipeline moved during stall");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && dv_v && dv_ovf && !dv_zero |=> o_propensity == '1)
        else $error("overflow not saturated");

endmodule

FILE: bench/michaelis_menten_propensity_top_tb.sv
// Testbench for the Michaelis-Menten propensity pipeline: directed and random requests.
module michaelis_menten_propensity_top_tb;
    import mmp_pkg::*;

    localparam int CB = COUNT_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic [PROP_W-1:0] PROP_SAT = {PROP_W{1'b1}};
    localparam int LIMIT = 600000;
    localparam int DRAIN_CYCLES = 130;

    typedef struct packed {
        logic [PROP_W-1:0] prop;
        logic [FREE_W-1:0] sfree;
        logic              undef;
    } t_rate;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CB-1:0]        i_substrate_count = '0;
    logic [CB-1:0]        i_enzyme_count = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [PROP_W-1:0]    o_propensity;
    logic [FREE_W-1:0]    o_free_substrate;
    logic                 o_undefined_rate;

    logic [31:0] km_cfg = '0;
    logic [31:0] kcat_cfg = '0;
    t_rate       rate_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    michaelis_menten_propensity_top dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("michaelis_menten_propensity_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= n) r = c;
        end
        return r;
    endfunction

    function automatic t_rate mm_rate(input logic [CB-1:0] s, input logic [CB-1:0] e);
        logic [63:0]  sf;
        logic [63:0]  neg;
        logic [63:0]  mag;
        logic [63:0]  root;
        logic [63:0]  sfree;
        logic [63:0]  den;
        logic [127:0] rad;
        logic [127:0] num;
        logic [127:0] q;
        t_rate        r;
        sf  = 64'(s) << FB;
        neg = 64'(km_cfg) + (64'(e) << FB);
        mag = (sf >= neg) ? sf - neg : neg - sf;
        rad = {64'd0, mag} * {64'd0, mag} + (({96'd0, km_cfg} * {64'd0, sf}) << 2);
        root = isqrt(rad);
        if (sf >= neg) sfree = (mag + root) >> 1;
        else sfree = (root >= mag) ? (root - mag) >> 1 : 64'd0;
        den = 64'(km_cfg) + sfree;
        r.sfree = (sfree > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sfree[31:0];
        if (den == 0) begin
            r.undef = 1'b1;
            r.prop  = '0;
        end else begin
            r.undef = 1'b0;
            num = {96'd0, kcat_cfg} * {64'd0, sfree} * {108'd0, e};
            q = num / {64'd0, den};
            r.prop = (q > {76'd0, PROP_SAT}) ? PROP_SAT : q[PROP_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rate exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rate_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = rate_q.pop_front();
                if (o_propensity !== exp_r.prop || o_free_substrate !== exp_r.sfree ||
                    o_undefined_rate !== exp_r.undef) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp prop %h free %h undef %b, got %h %h %b",
                                 exp_r.prop, exp_r.sfree, exp_r.undef,
                                 o_propensity, o_free_substrate, o_undefined_rate);
                end
            end
        end
    end

    task automatic send_req(input logic [CB-1:0] s, input logic [CB-1:0] e);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_substrate_count <= s;
        i_enzyme_count <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rate_q.push_back(mm_rate(s, e));
    endtask

    // wait for every outstanding request, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rate_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KM) km_cfg = val;
        else if (idx == CFG_KCAT) kcat_cfg = val;
    endtask

    task automatic set_rates(input logic [31:0] km, input logic [31:0] kcat);
        drain();
        write_reg(CFG_KM, km);
        write_reg(CFG_KCAT, kcat);
    endtask

    task automatic test_directed();
        logic [CB-1:0] mx;
        mx = '1;
        // reset values: Km = 0 gives a zero denominator when S = 0
        send_req('0, '0);
        send_req('0, mx);
        send_req(mx, '0);
        set_rates('0, '1);
        send_req('0, 20'd5);
        send_req(20'd1, 20'd1);
        send_req(mx, mx);
        send_req(mx, 20'd1);
        set_rates('1, '1);
        send_req(mx, mx);
        send_req('0, mx);
        send_req(mx, '0);
        send_req(20'd1, mx);
        // out-of-range indexes must leave both registers alone
        drain();
        write_reg(CFG_IDX_W'(2), 32'h1234_5678);
        write_reg(CFG_IDX_W'(3), 32'h0000_0001);
        send_req(20'd77, 20'd33);
        set_rates(32'h0000_1000, 32'h0001_0000);
        send_req(20'd1, 20'd1);
        send_req(20'd100, 20'd1000);
        send_req(20'd1000, 20'd100);
        send_req(mx, mx);
        set_rates(32'd1, '1);
        send_req('0, '0);
        send_req('0, 20'd1);
        send_req(mx, mx);
    endtask

    task automatic test_random(input int n, input int idle, input int stall,
                               input logic [31:0] km, input logic [31:0] kcat);
        logic [CB-1:0] s;
        logic [CB-1:0] e;
        set_rates(km, kcat);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin s = CB'($urandom); e = CB'($urandom); end
                1: begin s = CB'($urandom_range(255)); e = CB'($urandom_range(255)); end
                2: begin s = CB'($urandom); e = CB'($urandom_range(15)); end
                default: begin
                    s = ($urandom_range(1)) ? '0 : CB'($urandom);
                    e = ($urandom_range(1)) ? '0 : CB'($urandom);
                end
            endcase
            send_req(s, e);
            if (i == n / 2 && idle > 0) drain();
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250, 0, 0, $urandom, $urandom);
        test_random(250, 72, 0, 32'd0, '1);
        test_random(250, 0, 72, '1, $urandom);
        test_random(250, 30, 30, $urandom_range(65535), $urandom);
        test_random(250, 0, 0, '1, '1);
        drain();
        if (errors == 0 && rate_q.size() == 0)
            $display("michaelis_menten_propensity_top_tb: PASS");
        else
            $display("michaelis_menten_propensity_top_tb: FAIL");
        $finish;
    end

endmodule
